// ===== src/erpg_pkg.sv =====
// Package for the ellipse point generator: shared constants, operation codes and types.
package erpg_pkg;

    // Default coordinate width
    localparam int DEF_COORD_BITS = 12;

    // Shared multiplier operations
    localparam logic [1:0] MUL_AA = 2'd0;   // a * a
    localparam logic [1:0] MUL_BB = 2'd1;   // b * b
    localparam logic [1:0] MUL_DX = 2'd2;   // (1 - a) * b * b

    // Shared adder operations
    localparam logic [2:0] ADD_DX_DY  = 3'd0;  // dx + dy
    localparam logic [2:0] ADD_ODD    = 3'd1;  // err + (odd ? a*a : 0)
    localparam logic [2:0] ADD_DY_INC = 3'd2;  // dy + y_increment
    localparam logic [2:0] ADD_ERR_DY = 3'd3;  // err + dy
    localparam logic [2:0] ADD_DX_INC = 3'd4;  // dx + x_increment
    localparam logic [2:0] ADD_ERR_DX = 3'd5;  // err + dx

    // Shared comparator right-hand side (left side is always 2*err)
    localparam logic CMP_DX = 1'b0;
    localparam logic CMP_DY = 1'b1;

    // Operation select from sequencer to arithmetic unit
    typedef struct packed {
        logic [1:0] mul_op;
        logic [2:0] add_op;
        logic       cmp_op;
    } t_arith_ctl;

    // Comparator result: 2*err against the selected term
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_flags;

endpackage

// ===== src/erpg_arith.sv =====
// Shared arithmetic unit: one multiplier, one wide adder and one signed comparator.
module erpg_arith import erpg_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  t_arith_ctl                      i_ctl,
    input  logic [COORD_BITS-1:0]           i_a,
    input  logic [COORD_BITS-1:0]           i_b,
    input  logic                            i_odd,
    input  logic [2*COORD_BITS-1:0]         i_aa,
    input  logic [2*COORD_BITS-1:0]         i_bb,
    input  logic [3*COORD_BITS+7:0]         i_err,
    input  logic [3*COORD_BITS+7:0]         i_dx,
    input  logic [3*COORD_BITS+7:0]         i_dy,
    input  logic [2*COORD_BITS+3:0]         i_xinc,
    input  logic [2*COORD_BITS+3:0]         i_yinc,
    output logic signed [3*COORD_BITS+1:0]  o_prod,
    output logic [3*COORD_BITS+7:0]         o_sum,
    output t_cmp_flags                      o_cmp
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int ERR_W = 3 * COORD_BITS + 8;
    localparam int INC_W = 2 * COORD_BITS + 4;
    localparam int PRD_W = 3 * COORD_BITS + 2;

    logic signed [COORD_BITS:0] mul_a;
    logic        [SQ_W-1:0]     mul_b;
    logic signed [SQ_W:0]       mul_b_s;
    logic        [ERR_W-1:0]    add_x;
    logic        [ERR_W-1:0]    add_y;
    logic signed [ERR_W:0]      cmp_l;
    logic signed [ERR_W:0]      cmp_r;
    logic        [ERR_W-1:0]    cmp_sel;

    // Select multiplier operands
    always_comb begin
        unique case (i_ctl.mul_op)
            MUL_AA: begin
                mul_a = {1'b0, i_a};
                mul_b = {{COORD_BITS{1'b0}}, i_a};
            end
            MUL_BB: begin
                mul_a = {1'b0, i_b};
                mul_b = {{COORD_BITS{1'b0}}, i_b};
            end
            MUL_DX: begin
                mul_a = (COORD_BITS+1)'(1) - {1'b0, i_a};
                mul_b = i_bb;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_b_s = {1'b0, mul_b};
    assign o_prod  = PRD_W'(mul_a) * PRD_W'(mul_b_s);

    // Select adder operands
    always_comb begin
        unique case (i_ctl.add_op)
            ADD_DX_DY: begin
                add_x = i_dx;
                add_y = i_dy;
            end
            ADD_ODD: begin
                add_x = i_err;
                add_y = i_odd ? {{(ERR_W-SQ_W){1'b0}}, i_aa} : '0;
            end
            ADD_DY_INC: begin
                add_x = i_dy;
                add_y = {{(ERR_W-INC_W){1'b0}}, i_yinc};
            end
            ADD_ERR_DY: begin
                add_x = i_err;
                add_y = i_dy;
            end
            ADD_DX_INC: begin
                add_x = i_dx;
                add_y = {{(ERR_W-INC_W){1'b0}}, i_xinc};
            end
            ADD_ERR_DX: begin
                add_x = i_err;
                add_y = i_dx;
            end
            default: begin
                add_x = '0;
                add_y = '0;
            end
        endcase
    end

    assign o_sum = add_x + add_y;

    // Compare 2*err with dx or dy at full precision
    assign cmp_sel  = (i_ctl.cmp_op == CMP_DY) ? i_dy : i_dx;
    assign cmp_l    = {i_err, 1'b0};
    assign cmp_r    = {cmp_sel[ERR_W-1], cmp_sel};
    assign o_cmp.lt = cmp_l < cmp_r;
    assign o_cmp.eq = cmp_l == cmp_r;

endmodule

// ===== src/ellipse_rect_point_generator.sv =====
// Start: S_MAA to S_EODD. Step: S_CX to S_FIN (S_ERY, S_ERX if moving), or S_FIN alone if idle.
// A step result loads into the output register on leaving the last state, which waits while full.
// Throughput: one item at a time, set by the sequencer sharing one multiplier, adder, comparator.
// The next item is taken while a finished result still waits in the output register.
// Reset (synchronous, active low): sequencer idle, no ellipse active, output empty.
// Top level: sequencer and state registers of the midpoint ellipse rasterizer.
module ellipse_rect_point_generator import erpg_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_corner_ax,
    input  logic [COORD_BITS-1:0] i_corner_ay,
    input  logic [COORD_BITS-1:0] i_corner_bx,
    input  logic [COORD_BITS-1:0] i_corner_by,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_left_x,
    output logic [COORD_BITS-1:0] o_right_x,
    output logic [COORD_BITS-1:0] o_lower_y,
    output logic [COORD_BITS-1:0] o_upper_y,
    output logic                  o_points_valid,
    output logic                  o_finished
);

    localparam int POS_W = COORD_BITS + 2;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int ERR_W = 3 * COORD_BITS + 8;
    localparam int INC_W = 2 * COORD_BITS + 4;
    localparam int PRD_W = 3 * COORD_BITS + 2;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAA  = 4'd1;
    localparam logic [3:0] S_MBB  = 4'd2;
    localparam logic [3:0] S_MDX  = 4'd3;
    localparam logic [3:0] S_EDY  = 4'd4;
    localparam logic [3:0] S_EODD = 4'd5;
    localparam logic [3:0] S_CX   = 4'd6;
    localparam logic [3:0] S_CY   = 4'd7;
    localparam logic [3:0] S_ERY  = 4'd8;
    localparam logic [3:0] S_CX2  = 4'd9;
    localparam logic [3:0] S_ERX  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]            r_state, n_state;
    logic                  r_running, n_running;
    logic [COORD_BITS-1:0] r_a, n_a;
    logic [COORD_BITS-1:0] r_b, n_b;
    logic [POS_W-1:0]      r_left_x, n_left_x;
    logic [POS_W-1:0]      r_right_x, n_right_x;
    logic [POS_W-1:0]      r_lower_y, n_lower_y;
    logic [POS_W-1:0]      r_upper_y, n_upper_y;
    logic [SQ_W-1:0]       r_aa, n_aa;
    logic [SQ_W-1:0]       r_bb, n_bb;
    logic [ERR_W-1:0]      r_err, n_err;
    logic [ERR_W-1:0]      r_dx, n_dx;
    logic [ERR_W-1:0]      r_dy, n_dy;
    logic [INC_W-1:0]      r_xinc, n_xinc;
    logic [INC_W-1:0]      r_yinc, n_yinc;
    logic                  r_cx, n_cx;
    logic [COORD_BITS-1:0] r_p_left, n_p_left;
    logic [COORD_BITS-1:0] r_p_right, n_p_right;
    logic [COORD_BITS-1:0] r_p_lower, n_p_lower;
    logic [COORD_BITS-1:0] r_p_upper, n_p_upper;
    logic                  r_p_valid, n_p_valid;
    logic                  r_o_valid, n_o_valid;
    logic [COORD_BITS-1:0] r_o_left, n_o_left;
    logic [COORD_BITS-1:0] r_o_right, n_o_right;
    logic [COORD_BITS-1:0] r_o_lower, n_o_lower;
    logic [COORD_BITS-1:0] r_o_upper, n_o_upper;
    logic                  r_o_pv, n_o_pv;
    logic                  r_o_fin, n_o_fin;

    t_arith_ctl              ctl;
    t_cmp_flags              cmp;
    logic signed [PRD_W-1:0] prod;
    logic [ERR_W-1:0]        sum;

    logic                  accept;
    logic                  ax_lt;
    logic                  ay_lt;
    logic [COORD_BITS-1:0] s_a;
    logic [COORD_BITS-1:0] s_b;
    logic [COORD_BITS-1:0] s_ymin;
    logic                  crossed;
    logic                  out_free;

    erpg_arith #(
        .COORD_BITS (COORD_BITS)
    ) u_arith (
        .i_ctl  (ctl),
        .i_a    (r_a),
        .i_b    (r_b),
        .i_odd  (r_b[0]),
        .i_aa   (r_aa),
        .i_bb   (r_bb),
        .i_err  (r_err),
        .i_dx   (r_dx),
        .i_dy   (r_dy),
        .i_xinc (r_xinc),
        .i_yinc (r_yinc),
        .o_prod (prod),
        .o_sum  (sum),
        .o_cmp  (cmp)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign crossed  = $signed(r_left_x) > $signed(r_right_x);

    // Order the corners and take the axis lengths
    assign ax_lt  = i_corner_ax < i_corner_bx;
    assign ay_lt  = i_corner_ay < i_corner_by;
    assign s_a    = ax_lt ? (i_corner_bx - i_corner_ax) : (i_corner_ax - i_corner_bx);
    assign s_b    = ay_lt ? (i_corner_by - i_corner_ay) : (i_corner_ay - i_corner_by);
    assign s_ymin = ay_lt ? i_corner_ay : i_corner_by;

    // Drive the shared unit from the current state
    always_comb begin
        ctl.mul_op = MUL_AA;
        ctl.add_op = ADD_DX_DY;
        ctl.cmp_op = CMP_DX;
        unique case (r_state)
            S_MBB:  ctl.mul_op = MUL_BB;
            S_MDX:  ctl.mul_op = MUL_DX;
            S_EDY:  ctl.add_op = ADD_DX_DY;
            S_EODD: ctl.add_op = ADD_ODD;
            S_CX:   ctl.cmp_op = CMP_DX;
            S_CY: begin
                ctl.cmp_op = CMP_DY;
                ctl.add_op = ADD_DY_INC;
            end
            S_ERY:  ctl.add_op = ADD_ERR_DY;
            S_CX2: begin
                ctl.cmp_op = CMP_DY;
                ctl.add_op = ADD_DX_INC;
            end
            S_ERX:  ctl.add_op = ADD_ERR_DX;
            default: ctl.mul_op = MUL_AA;
        endcase
    end

    // Sequencer and datapath next state
    always_comb begin
        n_state   = r_state;
        n_running = r_running;
        n_a       = r_a;
        n_b       = r_b;
        n_left_x  = r_left_x;
        n_right_x = r_right_x;
        n_lower_y = r_lower_y;
        n_upper_y = r_upper_y;
        n_aa      = r_aa;
        n_bb      = r_bb;
        n_err     = r_err;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_xinc    = r_xinc;
        n_yinc    = r_yinc;
        n_cx      = r_cx;
        n_p_left  = r_p_left;
        n_p_right = r_p_right;
        n_p_lower = r_p_lower;
        n_p_upper = r_p_upper;
        n_p_valid = r_p_valid;
        n_o_left  = r_o_left;
        n_o_right = r_o_right;
        n_o_lower = r_o_lower;
        n_o_upper = r_o_upper;
        n_o_pv    = r_o_pv;
        n_o_fin   = r_o_fin;
        n_o_valid = r_o_valid && !i_ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        // Load corners for a new ellipse
                        n_a       = s_a;
                        n_b       = s_b;
                        n_left_x  = {2'b00, (ax_lt ? i_corner_ax : i_corner_bx)};
                        n_right_x = {2'b00, (ax_lt ? i_corner_bx : i_corner_ax)};
                        n_upper_y = {2'b00, s_ymin} + {3'b000, s_b[COORD_BITS-1:1]};
                        n_state   = S_MAA;
                    end else begin
                        // Capture the current points before advancing
                        n_p_valid = r_running;
                        n_p_left  = r_running ? r_left_x[COORD_BITS-1:0]  : '0;
                        n_p_right = r_running ? r_right_x[COORD_BITS-1:0] : '0;
                        n_p_lower = r_running ? r_lower_y[COORD_BITS-1:0] : '0;
                        n_p_upper = r_running ? r_upper_y[COORD_BITS-1:0] : '0;
                        n_state   = r_running ? S_CX : S_FIN;
                    end
                end
            end
            S_MAA: begin
                n_aa      = prod[SQ_W-1:0];
                n_yinc    = {1'b0, prod[SQ_W-1:0], 3'b000};
                n_lower_y = r_upper_y + {{(POS_W-1){1'b0}}, r_b[0]};
                n_state   = S_MBB;
            end
            S_MBB: begin
                n_bb    = prod[SQ_W-1:0];
                n_xinc  = {1'b0, prod[SQ_W-1:0], 3'b000};
                n_dy    = r_b[0] ? {{(ERR_W-SQ_W-3){1'b0}}, r_aa, 3'b000}
                                 : {{(ERR_W-SQ_W-2){1'b0}}, r_aa, 2'b00};
                n_state = S_MDX;
            end
            S_MDX: begin
                n_dx    = {{(ERR_W-PRD_W-2){prod[PRD_W-1]}}, prod, 2'b00};
                n_state = S_EDY;
            end
            S_EDY: begin
                n_err   = sum;
                n_state = S_EODD;
            end
            S_EODD: begin
                n_err     = sum;
                n_running = 1'b1;
                n_state   = S_IDLE;
            end
            S_CX: begin
                // Hold the x test on the error before the y move
                n_cx    = !cmp.lt;
                n_state = S_CY;
            end
            S_CY: begin
                if (cmp.lt || cmp.eq) begin
                    n_dy      = sum;
                    n_lower_y = r_lower_y + POS_W'(1);
                    n_upper_y = r_upper_y - POS_W'(1);
                    n_state   = S_ERY;
                end else begin
                    n_state = S_CX2;
                end
            end
            S_ERY: begin
                n_err   = sum;
                n_state = S_CX2;
            end
            S_CX2: begin
                if (r_cx || (!cmp.lt && !cmp.eq)) begin
                    n_dx      = sum;
                    n_left_x  = r_left_x + POS_W'(1);
                    n_right_x = r_right_x - POS_W'(1);
                    n_state   = S_ERX;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ERX: begin
                n_err   = sum;
                n_state = S_FIN;
            end
            S_FIN: begin
                // Load the result once the output register is free
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_left  = r_p_left;
                    n_o_right = r_p_right;
                    n_o_lower = r_p_lower;
                    n_o_upper = r_p_upper;
                    n_o_pv    = r_p_valid;
                    n_o_fin   = r_p_valid ? crossed : 1'b1;
                    if (r_p_valid) begin
                        n_running = !crossed;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath and payload registers
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_left_x  <= n_left_x;
        r_right_x <= n_right_x;
        r_lower_y <= n_lower_y;
        r_upper_y <= n_upper_y;
        r_aa      <= n_aa;
        r_bb      <= n_bb;
        r_err     <= n_err;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_xinc    <= n_xinc;
        r_yinc    <= n_yinc;
        r_cx      <= n_cx;
        r_p_left  <= n_p_left;
        r_p_right <= n_p_right;
        r_p_lower <= n_p_lower;
        r_p_upper <= n_p_upper;
        r_p_valid <= n_p_valid;
        r_o_left  <= n_o_left;
        r_o_right <= n_o_right;
        r_o_lower <= n_o_lower;
        r_o_upper <= n_o_upper;
        r_o_pv    <= n_o_pv;
        r_o_fin   <= n_o_fin;
    end

    assign o_valid        = r_o_valid;
    assign o_left_x       = r_o_left;
    assign o_right_x      = r_o_right;
    assign o_lower_y      = r_o_lower;
    assign o_upper_y      = r_o_upper;
    assign o_points_valid = r_o_pv;
    assign o_finished     = r_o_fin;

    // A result without points always reports the ellipse finished
    a_empty_is_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_points_valid |-> o_finished)
        else $error("result without points not flagged finished");

    // Setup completion leaves an ellipse active
    a_setup_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EODD |=> r_running)
        else $error("ellipse not active after setup");

    // A pending unfinished result implies the ellipse is still active
    a_open_result_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_points_valid && !o_finished |-> r_running)
        else $error("unfinished result while no ellipse active");

    // A step item taken on an active ellipse enters the step sequence
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_valid && o_ready) && $past(i_mode) && $past(r_running)
        |-> r_state == S_CX)
        else $error("step item did not enter the step sequence");

endmodule

// ===== tb/tb_ellipse_rect_point_generator.sv =====
// Self-checking testbench for the midpoint ellipse point generator, with a built-in predictor.
`timescale 1ns / 100ps

module tb_ellipse_rect_point_generator import erpg_pkg::*; ();

    localparam int  CB           = DEF_COORD_BITS;
    localparam bit  MODE_START   = 1'b0;
    localparam bit  MODE_STEP    = 1'b1;
    localparam int  RAND_ITEMS   = 1650;
    localparam int  DRAIN_CYCLES = 64;
    localparam int  CYCLE_LIMIT  = 1000000;

    // One emitted set of four symmetric points
    typedef struct packed {
        logic [CB-1:0] left_x;
        logic [CB-1:0] right_x;
        logic [CB-1:0] lower_y;
        logic [CB-1:0] upper_y;
        logic          points_valid;
        logic          finished;
    } t_pts;

    // One row of the directed stimulus table
    typedef struct packed {
        logic          mode;
        logic [CB-1:0] ax;
        logic [CB-1:0] ay;
        logic [CB-1:0] bx;
        logic [CB-1:0] by;
        logic          typed;
        t_pts          want;
    } t_dir_row;

    localparam t_pts NO_PTS = '{default: '0, finished: 1'b1};

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic          i_mode;
    logic [CB-1:0] i_corner_ax;
    logic [CB-1:0] i_corner_ay;
    logic [CB-1:0] i_corner_bx;
    logic [CB-1:0] i_corner_by;
    logic          o_valid;
    logic          i_ready;
    logic [CB-1:0] o_left_x;
    logic [CB-1:0] o_right_x;
    logic [CB-1:0] o_lower_y;
    logic [CB-1:0] o_upper_y;
    logic          o_points_valid;
    logic          o_finished;

    ellipse_rect_point_generator #(.COORD_BITS(CB)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_corner_ax    (i_corner_ax),
        .i_corner_ay    (i_corner_ay),
        .i_corner_bx    (i_corner_bx),
        .i_corner_by    (i_corner_by),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_x       (o_left_x),
        .o_right_x      (o_right_x),
        .o_lower_y      (o_lower_y),
        .o_upper_y      (o_upper_y),
        .o_points_valid (o_points_valid),
        .o_finished     (o_finished)
    );

    // Predicted rasterizer state
    logic signed [CB+1:0]   trk_left_x, trk_right_x, trk_lower_y, trk_upper_y;
    logic signed [3*CB+7:0] trk_err, trk_dx, trk_dy;
    logic [2*CB+3:0]        trk_x_inc, trk_y_inc;
    bit                     trk_running;

    t_pts     pending_pts[$];
    t_dir_row dir_tab[$];
    t_pts     got_pts;
    t_pts     want_pts;
    int       n_err;
    int       n_sent;
    int       n_cycles;
    int       stall_left;
    bit       burst;

    // Clock: 8 ns period
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Load a new ellipse from two corners
    function automatic void load_ellipse(longint ax, longint ay, longint bx, longint by);
        longint a, b, odd, ylo, v;
        a   = (ax > bx) ? ax - bx : bx - ax;
        b   = (ay > by) ? ay - by : by - ay;
        odd = b & 1;
        v   = 4 * (1 - a) * b * b;
        trk_dx = v[3*CB+7:0];
        v   = 4 * (odd + 1) * a * a;
        trk_dy = v[3*CB+7:0];
        v   = 4 * (1 - a) * b * b + 4 * (odd + 1) * a * a + odd * a * a;
        trk_err = v[3*CB+7:0];
        ylo = ((ay < by) ? ay : by) + (b + 1) / 2;
        trk_left_x  = (CB+2)'((ax < bx) ? ax : bx);
        trk_right_x = (CB+2)'((ax < bx) ? bx : ax);
        trk_lower_y = (CB+2)'(ylo);
        trk_upper_y = (CB+2)'(ylo - odd);
        v   = 8 * a * a;
        trk_y_inc = v[2*CB+3:0];
        v   = 8 * b * b;
        trk_x_inc = v[2*CB+3:0];
        trk_running = 1'b1;
    endfunction

    // Emit the current points, then advance the error terms one step
    function automatic t_pts advance_points();
        t_pts   r;
        longint e2;
        if (!trk_running)
            return NO_PTS;
        r.left_x       = trk_left_x[CB-1:0];
        r.right_x      = trk_right_x[CB-1:0];
        r.lower_y      = trk_lower_y[CB-1:0];
        r.upper_y      = trk_upper_y[CB-1:0];
        r.points_valid = 1'b1;
        e2 = 2 * longint'(trk_err);
        if (e2 <= longint'(trk_dy)) begin
            trk_lower_y = (CB+2)'(trk_lower_y + 1);
            trk_upper_y = (CB+2)'(trk_upper_y - 1);
            trk_dy      = trk_dy + trk_y_inc;
            trk_err     = trk_err + trk_dy;
        end
        if (e2 >= longint'(trk_dx) || 2 * longint'(trk_err) > longint'(trk_dy)) begin
            trk_left_x  = (CB+2)'(trk_left_x + 1);
            trk_right_x = (CB+2)'(trk_right_x - 1);
            trk_dx      = trk_dx + trk_x_inc;
            trk_err     = trk_err + trk_dx;
        end
        if (trk_left_x > trk_right_x)
            trk_running = 1'b0;
        r.finished = !trk_running;
        return r;
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Drive one item, wait for acceptance, then record what it should produce
    task automatic drive_item(logic mode, logic [CB-1:0] ax, logic [CB-1:0] ay,
                              logic [CB-1:0] bx, logic [CB-1:0] by,
                              logic typed, t_pts want);
        int   gap;
        t_pts pred;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_corner_ax <= ax;
        i_corner_ay <= ay;
        i_corner_bx <= bx;
        i_corner_by <= by;
        do
            @(posedge i_clk);
        while (!o_ready);
        n_sent++;
        if (mode == MODE_START) begin
            load_ellipse(ax, ay, bx, by);
        end else begin
            pred = advance_points();
            pending_pts.push_back(typed ? want : pred);
        end
    endtask

    task automatic drive_step();
        drive_item(MODE_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                   1'b0, NO_PTS);
    endtask

    // Hold the sender until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pts.size() != 0)
            @(posedge i_clk);
    endtask

    // Append one row to the directed table
    task automatic add_row(logic mode, int ax, int ay, int bx, int by, logic typed,
                           int lx, int rx, int ly, int uy, logic pv, logic fin);
        t_dir_row row;
        row.mode  = mode;
        row.ax    = CB'(ax);
        row.ay    = CB'(ay);
        row.bx    = CB'(bx);
        row.by    = CB'(by);
        row.typed = typed;
        row.want  = '{left_x: CB'(lx), right_x: CB'(rx), lower_y: CB'(ly),
                      upper_y: CB'(uy), points_valid: pv, finished: fin};
        dir_tab.push_back(row);
    endtask

    // Pick two coordinates along one axis: mostly small spans, a few large
    task automatic pick_span(output logic [CB-1:0] c0, output logic [CB-1:0] c1,
                             output bit wide);
        int r, sz, base;
        r = $urandom_range(0, 99);
        wide = 1'b0;
        if (r < 88) begin
            sz = $urandom_range(0, 31);
        end else if (r < 98) begin
            sz = $urandom_range(32, 255);
        end else begin
            sz   = $urandom_range(256, (1 << CB) - 1);
            wide = 1'b1;
        end
        base = $urandom_range(0, (1 << CB) - 1 - sz);
        if ($urandom_range(0, 1)) begin
            c0 = CB'(base);
            c1 = CB'(base + sz);
        end else begin
            c0 = CB'(base + sz);
            c1 = CB'(base);
        end
    endtask

    // Receiver: random stalls, mostly short, a few long
    always @(negedge i_clk) begin
        int r;
        if (burst) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_ready <= 1'b1;
            end else begin
                i_ready    <= 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
        end
    end

    function automatic void check_field(string nm, logic [CB-1:0] want, logic [CB-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
            n_err++;
        end
    endfunction

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_pts = '{left_x: o_left_x, right_x: o_right_x, lower_y: o_lower_y,
                        upper_y: o_upper_y, points_valid: o_points_valid,
                        finished: o_finished};
            if (pending_pts.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got_pts);
                n_err++;
            end else begin
                want_pts = pending_pts.pop_front();
                check_field("left_x", want_pts.left_x, got_pts.left_x);
                check_field("right_x", want_pts.right_x, got_pts.right_x);
                check_field("lower_y", want_pts.lower_y, got_pts.lower_y);
                check_field("upper_y", want_pts.upper_y, got_pts.upper_y);
                check_field("points_valid", CB'(want_pts.points_valid),
                            CB'(got_pts.points_valid));
                check_field("finished", CB'(want_pts.finished), CB'(got_pts.finished));
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [CB-1:0] ax, ay, bx, by;
        bit            wide_x, wide_y;
        int            walk, next_drain;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_mode      = MODE_STEP;
        i_corner_ax = '0;
        i_corner_ay = '0;
        i_corner_bx = '0;
        i_corner_by = '0;
        n_err       = 0;
        n_sent      = 0;
        n_cycles    = 0;
        stall_left  = 0;
        burst       = 1'b0;
        trk_running = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: typed results where they follow at a glance
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0,    0,    0,    0, 0, 1);
        add_row(MODE_START,    0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0,    0,    0,    0, 1, 1);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0,    0,    0,    0, 0, 1);
        add_row(MODE_START, 4095, 4095,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0, 4095, 2048, 2047, 1, 0);
        add_row(MODE_STEP,  4095, 4095, 4095, 4095, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        // Restart while an ellipse is still running
        add_row(MODE_START,   10,   20,    3,    5, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_START,    0, 4095, 4095,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0, 4095, 2048, 2047, 1, 0);
        // Flat ellipse: zero height
        add_row(MODE_START,  100,   50,  200,   50, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 0,    0,    0,    0,    0, 0, 0);
        // Zero width, full height: one step and done
        add_row(MODE_START,    7, 4095,    7,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    7,    7, 2048, 2047, 1, 1);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0,    0,    0,    0, 0, 1);
        add_row(MODE_START, 4095,    0, 4095,    0, 0,    0,    0,    0,    0, 0, 0);
        add_row(MODE_STEP,     0,    0,    0,    0, 1, 4095, 4095,    0,    0, 1, 1);
        add_row(MODE_STEP,     0,    0,    0,    0, 1,    0,    0,    0,    0, 0, 1);

        foreach (dir_tab[i])
            drive_item(dir_tab[i].mode, dir_tab[i].ax, dir_tab[i].ay, dir_tab[i].bx,
                       dir_tab[i].by, dir_tab[i].typed, dir_tab[i].want);
        drain_results();

        // Random part: mostly whole ellipses, some abandoned, some noise
        next_drain = n_sent + 300;
        while (n_sent < RAND_ITEMS + dir_tab.size()) begin
            if ($urandom_range(0, 19) == 0)
                burst = !burst;
            if (n_sent >= next_drain) begin
                drain_results();
                next_drain = n_sent + 300;
            end
            if ($urandom_range(0, 99) < 85) begin
                pick_span(ax, bx, wide_x);
                pick_span(ay, by, wide_y);
                drive_item(MODE_START, ax, ay, bx, by, 1'b0, NO_PTS);
                if (wide_x || wide_y)
                    walk = $urandom_range(10, 60);
                else if ($urandom_range(0, 9) == 0)
                    walk = $urandom_range(0, 8);
                else
                    walk = -1;
                while (trk_running && walk != 0) begin
                    drive_step();
                    if (walk > 0)
                        walk--;
                end
                // Step past the end now and then
                if (!trk_running && $urandom_range(0, 9) < 3)
                    repeat ($urandom_range(1, 2)) drive_step();
            end else begin
                drive_item(1'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
                           CB'($urandom), CB'($urandom), 1'b0, NO_PTS);
            end
        end

        // Let the last results arrive, then watch for strays
        burst = 1'b1;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
